[rtl/ldf_pkg.sv]
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared types, constants and the CRC-16 step function for the frame
// deframer (header, length, payload, CRC-16, tail).
// ----------------------------------------------------------------------------
package ldf_pkg;

    // payload store geometry
    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int CRC_W  = 16;

    // frame constants
    localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'h02;
    localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'h03;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;

    // limit register reset value
    localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;

    // command queue between parser and drain side
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EMIT  = 1'b1
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   data;
        logic [LEN_W-1:0]    len;
    } cmd_t;

    // one byte of xmodem crc, msb first
    function automatic logic [CRC_W-1:0] crc16_update(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data_in
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/ldf_front.sv]
// ----------------------------------------------------------------------------
// ldf_front
// Frame parser: takes received bytes, tracks the frame phase and CRC, and
// issues store-write and frame-emit commands into the queue.
// ----------------------------------------------------------------------------
module ldf_front import ldf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [LEN_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_TAIL = 4'b1000
    } phase_t;

    localparam logic [LEN_W-1:0] BufDepthLen = LEN_W'(BUF_DEPTH);

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    limit_reg;
    logic [LEN_W-1:0]    exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]    seen_reg, seen_next;
    logic [CRC_W-1:0]    crc_reg, crc_next;
    logic [BYTE_W-1:0]   crc_hi_reg, crc_hi_next;
    logic                crc_ok_reg, crc_ok_next;
    logic [LEN_W-1:0]    limit_eff;
    logic                take;

    // accept whenever the queue has room
    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    // effective length limit, capped to the store
    assign limit_eff = (limit_reg > BufDepthLen) ? BufDepthLen : limit_reg;

    // limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // phase and frame tracking
    always_comb begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        crc_next     = crc_reg;
        crc_hi_next  = crc_hi_reg;
        crc_ok_next  = crc_ok_reg;
        q_push       = 1'b0;
        q_cmd        = '0;
        if (take) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (s_rx_byte == HDR_BYTE) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (s_rx_byte == '0 || s_rx_byte > {1'b0, limit_eff}) begin
                        phase_next = PH_HUNT;
                    end else begin
                        exp_len_next = s_rx_byte[LEN_W-1:0];
                        seen_next    = '0;
                        crc_next     = '0;
                        crc_hi_next  = '0;
                        crc_ok_next  = 1'b0;
                        phase_next   = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (seen_reg < exp_len_reg) begin
                        q_push      = 1'b1;
                        q_cmd.op    = OP_WRITE;
                        q_cmd.addr  = seen_reg[ADDR_W-1:0];
                        q_cmd.data  = s_rx_byte;
                        crc_next    = crc16_update(crc_reg, s_rx_byte);
                        seen_next   = seen_reg + 1'b1;
                    end else if (seen_reg == exp_len_reg) begin
                        crc_hi_next = s_rx_byte;
                        seen_next   = seen_reg + 1'b1;
                    end else begin
                        crc_ok_next = ({crc_hi_reg, s_rx_byte} == crc_reg);
                        phase_next  = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if (s_rx_byte == TAIL_BYTE && crc_ok_reg) begin
                        q_push    = 1'b1;
                        q_cmd.op  = OP_EMIT;
                        q_cmd.len = exp_len_reg;
                    end
                    phase_next = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            exp_len_reg <= '0;
            seen_reg    <= '0;
            crc_reg     <= '0;
            crc_hi_reg  <= '0;
            crc_ok_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            seen_reg    <= seen_next;
            crc_reg     <= crc_next;
            crc_hi_reg  <= crc_hi_next;
            crc_ok_reg  <= crc_ok_next;
        end
    end

endmodule

[rtl/ldf_queue.sv]
// ----------------------------------------------------------------------------
// ldf_queue
// Small command fifo between the parser and the drain side.
// ----------------------------------------------------------------------------
module ldf_queue import ldf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/ldf_back.sv]
// ----------------------------------------------------------------------------
// ldf_back
// Drain side: executes queued commands, writing the payload store and
// reading a validated frame back out one byte per transfer.
// ----------------------------------------------------------------------------
module ldf_back import ldf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_payload_byte,
    output logic              m_last_byte,
    output logic [LEN_W-1:0]  m_frame_length
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SEND = 3'b100
    } back_state_t;

    logic [BYTE_W-1:0] store_mem [BUF_DEPTH];
    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              is_last;
    logic              store_wr;

    assign is_last = ((LEN_W'(idx_reg) + 1'b1) == len_reg);

    // command pop and emit sequencing
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        q_pop      = 1'b0;
        store_wr   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_cmd.op == OP_EMIT) begin
                        len_next   = q_cmd.len;
                        idx_next   = '0;
                        state_next = ST_READ;
                    end else begin
                        store_wr = 1'b1;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // payload store write port
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[q_cmd.addr] <= q_cmd.data;
        end
    end

    // payload store read port, registered
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
        end
    end

    // result channel
    assign m_valid        = (state_reg == ST_SEND);
    assign m_payload_byte = rd_data_reg;
    assign m_last_byte    = is_last;
    assign m_frame_length = len_reg;

endmodule

[rtl/length_crc_frame_deframer.sv]
// Flow: a received byte is parsed in the cycle it is taken; a good tail
// pushes an emit command into the queue, which the drain side pops when idle.
// Throughput: one received byte per cycle while the 4-entry command queue has
// room; the drain side retires one store write per cycle while idle, and sends
// each payload byte by a store read, then output, before reading the next.
// Reset: synchronous, active low; clears phase, queue and drain state, sets the
// length limit to 64; the payload store is not cleared.
// ----------------------------------------------------------------------------
// length_crc_frame_deframer
// Header / length / payload / CRC-16 / tail deframer for received serial bytes.
// ----------------------------------------------------------------------------
module length_crc_frame_deframer import ldf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [LEN_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_payload_byte,
    output logic              m_last_byte,
    output logic [LEN_W-1:0]  m_frame_length
);

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_push_cmd, q_pop_cmd;

    // parser
    ldf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_push_cmd)
    );

    // command queue
    ldf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    // store and output side
    ldf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_cmd          (q_pop_cmd),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_last_byte    (m_last_byte),
        .m_frame_length (m_frame_length)
    );

    // no push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("command pushed into full queue");

    // no pop from an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    // the last byte of a frame ends the burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_byte) |=> !m_valid)
        else $error("output still valid after last byte transfer");

    // a frame being sent has a nonzero length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_length != '0))
        else $error("frame sent with zero length");

endmodule
